[rtl/hcbp_pkg.sv]
// Package for the Huffman code bit packer: field widths, operation codes,
// queue sizing, back-end state type and the queue status bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

  localparam int SYM_W            = 8;
  localparam int CODE_W           = 32;
  localparam int LEN_W            = 6;
  localparam int BYTE_W           = 8;
  localparam int OP_W             = 2;
  localparam int NUM_SYMS         = 256;
  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int IN_TDATA_W       = 48;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

  // Queue between front and back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    KIND_ENCODE,
    KIND_FLUSH
  } item_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  typedef struct packed {
    logic              not_empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage : hcbp_pkg

`default_nettype wire

[rtl/hcbp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule : hcbp_ram

`default_nettype wire

[rtl/hcbp_front.sv]
// Front end: accepts input transfers, writes code table entries, reads the
// table for encodes and pushes encode and flush work into the queue.
// Depends on hcbp_pkg and hcbp_ram.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_front #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int CAP          = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                                 : hcbp_pkg::CODE_W,
  parameter int LENW         = $clog2(CAP + 1),
  parameter int EW           = 1 + CAP + LENW
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [hcbp_pkg::OP_W-1:0]       in_op,
  input  wire logic [hcbp_pkg::SYM_W-1:0]      in_sym,
  input  wire logic [hcbp_pkg::CODE_W-1:0]     in_code,
  input  wire logic [hcbp_pkg::LEN_W-1:0]      in_len,
  input  wire hcbp_pkg::q_status_t             q_stat,
  output logic                                 push,
  output logic      [EW-1:0]                   push_data
);

  localparam logic [hcbp_pkg::LEN_W-1:0] CAP_L = hcbp_pkg::LEN_W'(CAP);
  localparam int CW = hcbp_pkg::QCNT_W + 1;

  logic                            accept;
  logic                            load_we;
  logic [hcbp_pkg::LEN_W-1:0]      sat_len;
  logic [CAP+LENW-1:0]             ram_wdata;
  logic [CAP+LENW-1:0]             ram_rdata;
  logic [hcbp_pkg::NUM_SYMS-1:0]   vld_r, vld_nxt;
  logic                            f_vld_r, f_vld_nxt;
  hcbp_pkg::item_kind_t            f_kind_r, f_kind_nxt;
  logic                            f_hit_r, f_hit_nxt;
  logic [LENW-1:0]                 entry_len;

  // Room is reserved for the item still waiting on its table read.
  assign in_tready = (CW'(q_stat.count) + CW'(f_vld_r)) < CW'(hcbp_pkg::QUEUE_DEPTH);
  assign accept    = in_tvalid && in_tready;
  assign load_we   = accept && (in_op == hcbp_pkg::OP_LOAD);
  assign sat_len   = (in_len > CAP_L) ? CAP_L : in_len;
  assign ram_wdata = {in_code[CAP-1:0], LENW'(sat_len)};

  hcbp_ram #(
    .WIDTH(CAP + LENW),
    .DEPTH(hcbp_pkg::NUM_SYMS)
  ) u_table (
    .clk  (clk),
    .we   (load_we),
    .waddr(in_sym),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(in_sym),
    .rdata(ram_rdata)
  );

  always_comb begin
    vld_nxt    = vld_r;
    f_vld_nxt  = 1'b0;
    f_kind_nxt = f_kind_r;
    f_hit_nxt  = f_hit_r;
    if (load_we) begin
      vld_nxt[in_sym] = 1'b1;
    end
    if (accept && (in_op == hcbp_pkg::OP_ENCODE || in_op == hcbp_pkg::OP_FLUSH)) begin
      f_vld_nxt  = 1'b1;
      f_kind_nxt = (in_op == hcbp_pkg::OP_FLUSH) ? hcbp_pkg::KIND_FLUSH
                                                 : hcbp_pkg::KIND_ENCODE;
      f_hit_nxt  = vld_r[in_sym];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      f_vld_r <= 1'b0;
    end else begin
      vld_r   <= vld_nxt;
      f_vld_r <= f_vld_nxt;
    end
    f_kind_r <= f_kind_nxt;
    f_hit_r  <= f_hit_nxt;
  end

  // An entry never loaded reads as the empty code; a flush carries no bits.
  assign entry_len = (f_hit_r && f_kind_r == hcbp_pkg::KIND_ENCODE) ? ram_rdata[LENW-1:0]
                                                                    : '0;
  assign push      = f_vld_r;
  assign push_data = {f_kind_r, ram_rdata[CAP+LENW-1:LENW], entry_len};

endmodule : hcbp_front

`default_nettype wire

[rtl/hcbp_queue.sv]
// Short work queue between the front end and the packing back end.
// Depends on hcbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_queue #(
  parameter int WIDTH = 39
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] head_data,
  output hcbp_pkg::q_status_t   q_stat
);

  localparam int PW = $clog2(hcbp_pkg::QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(hcbp_pkg::QUEUE_DEPTH - 1);

  logic [WIDTH-1:0]            slot_r [hcbp_pkg::QUEUE_DEPTH];
  logic [PW-1:0]               wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]               rd_ptr_r, rd_ptr_nxt;
  logic [hcbp_pkg::QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + hcbp_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - hcbp_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_data = slot_r[rd_ptr_r];
  assign q_stat    = {(count_r != '0), count_r};

endmodule : hcbp_queue

`default_nettype wire

[rtl/hcbp_back.sv]
// Back end: takes work from the queue, packs code bits into bytes up to eight
// bits a step and drives the output register. Depends on hcbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_back #(
  parameter int CAP  = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int LENW = $clog2(CAP + 1),
  parameter int EW   = 1 + CAP + LENW
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire hcbp_pkg::q_status_t         q_stat,
  input  wire logic [EW-1:0]               head_data,
  output logic                             pop,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [hcbp_pkg::BYTE_W-1:0] out_byte,
  output logic                             out_last
);

  localparam int SHW = (CAP < 8) ? 8 : CAP;
  localparam int NW  = (LENW > 4) ? LENW : 4;

  hcbp_pkg::back_state_t           state_r, state_nxt;
  hcbp_pkg::item_kind_t            kind_r, kind_nxt;
  logic [SHW-1:0]                  sh_r, sh_nxt;
  logic [LENW-1:0]                 rem_r, rem_nxt;
  logic [7:0]                      acc_r, acc_nxt;
  logic [2:0]                      pend_r, pend_nxt;
  logic                            out_vld_r, out_vld_nxt;
  logic [7:0]                      out_byte_r, out_byte_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            can_emit;
  logic                            emit;
  logic [NW-1:0]                   space;
  logic [NW-1:0]                   take;
  logic [NW-1:0]                   fill;
  logic                            full;
  logic [LENW-1:0]                 rem_after;
  logic [7:0]                      top8;
  logic [7:0]                      acc_new;
  logic [LENW-1:0]                 head_len;
  logic [CAP-1:0]                  head_code;
  logic [NW-1:0]                   align;

  assign head_len  = head_data[LENW-1:0];
  assign head_code = head_data[EW-2 -: CAP];
  assign align     = NW'(SHW) - NW'(head_len);

  assign can_emit  = !out_vld_r || out_tready;
  assign space     = NW'(8) - NW'(pend_r);
  assign take      = (NW'(rem_r) < space) ? NW'(rem_r) : space;
  assign fill      = NW'(pend_r) + take;
  assign full      = (fill == NW'(8));
  assign rem_after = rem_r - LENW'(take);
  assign top8      = sh_r[SHW-1 -: 8];
  assign acc_new   = acc_r | (top8 >> pend_r);

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    sh_nxt       = sh_r;
    rem_nxt      = rem_r;
    acc_nxt      = acc_r;
    pend_nxt     = pend_r;
    pop          = 1'b0;
    emit         = 1'b0;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    unique case (state_r)
      hcbp_pkg::BK_IDLE: begin
        if (q_stat.not_empty) begin
          pop       = 1'b1;
          kind_nxt  = hcbp_pkg::item_kind_t'(head_data[EW-1]);
          // Left-align the code so the first bit sits at the top.
          sh_nxt    = SHW'(head_code) << align;
          rem_nxt   = head_len;
          state_nxt = hcbp_pkg::BK_RUN;
        end
      end
      hcbp_pkg::BK_RUN: begin
        if (kind_r == hcbp_pkg::KIND_FLUSH) begin
          if (pend_r == '0) begin
            acc_nxt   = '0;
            state_nxt = hcbp_pkg::BK_IDLE;
          end else if (can_emit) begin
            emit         = 1'b1;
            out_byte_nxt = acc_r;
            out_last_nxt = 1'b1;
            acc_nxt      = '0;
            pend_nxt     = '0;
            state_nxt    = hcbp_pkg::BK_IDLE;
          end
        end else if (rem_r == '0) begin
          state_nxt = hcbp_pkg::BK_IDLE;
        end else if (!full) begin
          acc_nxt   = acc_new;
          pend_nxt  = fill[2:0];
          sh_nxt    = sh_r << take;
          rem_nxt   = rem_after;
          if (rem_after == '0) begin
            state_nxt = hcbp_pkg::BK_IDLE;
          end
        end else if (can_emit) begin
          emit         = 1'b1;
          out_byte_nxt = acc_new;
          // Marked last when fewer than eight code bits of the item remain after this byte.
          out_last_nxt = (NW'(rem_after) < NW'(8));
          acc_nxt      = '0;
          pend_nxt     = '0;
          sh_nxt       = sh_r << take;
          rem_nxt      = rem_after;
          if (rem_after == '0) begin
            state_nxt = hcbp_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = hcbp_pkg::BK_IDLE;
      end
    endcase
    out_vld_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= hcbp_pkg::BK_IDLE;
      acc_r     <= '0;
      pend_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      acc_r     <= acc_nxt;
      pend_r    <= pend_nxt;
      out_vld_r <= out_vld_nxt;
    end
    kind_r     <= kind_nxt;
    sh_r       <= sh_nxt;
    rem_r      <= rem_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;

`ifndef SYNTHESIS
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hcbp_pkg::BK_RUN && kind_r == hcbp_pkg::KIND_FLUSH &&
     (pend_r == '0 || can_emit)) |=> (pend_r == '0 && acc_r == '0))
    else $error("flush left bits in the accumulator");

  a_last_ends_code: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && out_last_nxt) |=> (NW'(rem_r) < NW'(8)))
    else $error("last byte emitted with a further byte of code bits remaining");

  a_rose_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == hcbp_pkg::BK_RUN))
    else $error("output became valid outside the packing state");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == hcbp_pkg::BK_RUN))
    else $error("dequeued item did not start packing");
`endif

endmodule : hcbp_back

`default_nettype wire

[rtl/huffman_code_bit_packer.sv]
// Top level of the Huffman code bit packer: front end with code table,
// work queue and packing back end. Depends on hcbp_pkg, hcbp_front,
// hcbp_queue and hcbp_back.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake              Payload
// in_      slave      in_tvalid/in_tready    tuser: operation; tdata: symbol,
//                                            code_word, code_length
// out_     master     out_tvalid/out_tready  tdata: packed_byte; tlast: run_last
//
// A load writes the table and gives no result. An encode passes through the
// front end (transfer, table read), is dequeued by the back end and is packed
// in steps of up to eight bits. A flush emits any pending bits as a last byte.
// Reset clears all table valid flags at once, so there is no clearing pass.
// While a byte waits and out_tready is low the packer holds before its next
// full byte; the four-entry queue takes work until full.

module huffman_code_bit_packer #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [45:40] code_length, [39:8] code_word, [7:0] symbol, [47:46] zero
  input  wire logic [hcbp_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] operation
  input  wire logic [hcbp_pkg::OP_W-1:0]         in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [7:0] packed_byte
  output logic      [hcbp_pkg::BYTE_W-1:0]       out_tdata,
  output logic                                   out_tlast
);

  // Lengths are capped at the smaller of MAX_CODE_LEN and the code word width.
  localparam int CAP  = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN : hcbp_pkg::CODE_W;
  localparam int LENW = $clog2(CAP + 1);
  localparam int EW   = 1 + CAP + LENW;

  hcbp_pkg::q_status_t q_stat;
  logic                push;
  logic [EW-1:0]       push_data;
  logic                pop;
  logic [EW-1:0]       head_data;

  // Front end: table writes on load, table reads on encode.
  hcbp_front #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .CAP         (CAP),
    .LENW        (LENW),
    .EW          (EW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_op    (in_tuser),
    .in_sym   (in_tdata[7:0]),
    .in_code  (in_tdata[39:8]),
    .in_len   (in_tdata[45:40]),
    .q_stat   (q_stat),
    .push     (push),
    .push_data(push_data)
  );

  // Queue entries carry the item kind, the code bits and the code length.
  hcbp_queue #(
    .WIDTH(EW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head_data(head_data),
    .q_stat   (q_stat)
  );

  // Back end: the bit accumulator and the output register.
  hcbp_back #(
    .CAP (CAP),
    .LENW(LENW),
    .EW  (EW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_data (head_data),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule : huffman_code_bit_packer

`default_nettype wire
